// File: rtl/pde_pkg.sv
// ----------------------------------------------------------------------------
// pde_pkg
// Shared widths, register indexes, control-word layout and the microprogram
// of the programmable difference equation.
// ----------------------------------------------------------------------------
package pde_pkg;

    // Item and register widths.
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int DELAY_W   = 4;
    localparam int TERM_W    = 21;
    localparam int COUNT_W   = 3;
    localparam int TERM_REGS = 7;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = COEF_W + SAMPLE_W + 1;
    localparam int FRAC_W    = 8;

    // Bit positions inside a term register.
    localparam int DELAY_LSB  = 16;
    localparam int OUTSEL_BIT = 20;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_TERMS     = 7;
    localparam int DEF_HISTORY_DEPTH = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_COUNT = 3'd0;
    localparam int                   CFG_TERM_BASE  = 1;

    // Reset values of the configuration registers: one pass-through term.
    localparam logic [COUNT_W-1:0] TERM_COUNT_RST = 3'd1;
    localparam logic [TERM_W-1:0]  TERM_0_RST     = 21'd256;

    typedef logic [TERM_REGS-1:0][TERM_W-1:0] term_array_t;

    // All term registers at reset: term 0 passes x(k) through, the rest are clear.
    localparam term_array_t TERM_REGS_RST = {{(TERM_REGS - 1){TERM_W'(0)}}, TERM_0_RST};

    // Microprogram step addresses.
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_LOOP   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_DRAIN0 = 3'd2;
    localparam logic [STEP_W-1:0] STEP_DRAIN1 = 3'd3;
    localparam logic [STEP_W-1:0] STEP_FINISH = 3'd4;

    // Wait conditions: the step is held while the condition is true.
    localparam logic [1:0] WC_NONE     = 2'd0;
    localparam logic [1:0] WC_NO_INPUT = 2'd1;
    localparam logic [1:0] WC_OUT_BUSY = 2'd2;

    // Jump conditions: taken once the wait is over.
    localparam logic [1:0] JC_NEVER      = 2'd0;
    localparam logic [1:0] JC_ALWAYS     = 2'd1;
    localparam logic [1:0] JC_MORE_TERMS = 2'd2;

    typedef struct packed {
        logic              take_in;
        logic              issue;
        logic              finish;
        logic [1:0]        wait_cond;
        logic [1:0]        jump_cond;
        logic [STEP_W-1:0] jump_target;
    } ctrl_word_t;

    // Conditions reported back to the sequencer.
    typedef struct packed {
        logic no_input;
        logic out_busy;
        logic more_terms;
    } pde_status_t;

    // Qualified actions handed to the datapath.
    typedef struct packed {
        logic accept;
        logic issue;
        logic finish;
    } pde_op_t;

    // Control store.
    function automatic ctrl_word_t rom_word(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        w = '0;
        case (step)
            STEP_IDLE: begin
                w.take_in   = 1'b1;
                w.wait_cond = WC_NO_INPUT;
            end
            STEP_LOOP: begin
                w.issue       = 1'b1;
                w.jump_cond   = JC_MORE_TERMS;
                w.jump_target = STEP_LOOP;
            end
            STEP_DRAIN0: begin
                w.jump_cond = JC_NEVER;
            end
            STEP_DRAIN1: begin
                w.jump_cond = JC_NEVER;
            end
            STEP_FINISH: begin
                w.finish      = 1'b1;
                w.wait_cond   = WC_OUT_BUSY;
                w.jump_cond   = JC_ALWAYS;
                w.jump_target = STEP_IDLE;
            end
            default: begin
                w.jump_cond   = JC_ALWAYS;
                w.jump_target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: rtl/pde_ram.sv
// ----------------------------------------------------------------------------
// pde_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pde_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/pde_sequencer.sv
// ----------------------------------------------------------------------------
// pde_sequencer
// Step counter over the control store, with wait and jump conditions.
// ----------------------------------------------------------------------------
module pde_sequencer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pde_pkg::pde_status_t status,
    output pde_pkg::ctrl_word_t  ctrl
);

    logic [pde_pkg::STEP_W-1:0] step_reg;
    logic [pde_pkg::STEP_W-1:0] step_next;
    logic                       wait_hit;
    logic                       jump_hit;

    assign ctrl = pde_pkg::rom_word(step_reg);

    always_comb begin
        case (ctrl.wait_cond)
            pde_pkg::WC_NO_INPUT: wait_hit = status.no_input;
            pde_pkg::WC_OUT_BUSY: wait_hit = status.out_busy;
            default:              wait_hit = 1'b0;
        endcase
        case (ctrl.jump_cond)
            pde_pkg::JC_ALWAYS:     jump_hit = 1'b1;
            pde_pkg::JC_MORE_TERMS: jump_hit = status.more_terms;
            default:                jump_hit = 1'b0;
        endcase
        if (wait_hit) begin
            step_next = step_reg;
        end else if (jump_hit) begin
            step_next = ctrl.jump_target;
        end else begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= pde_pkg::STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

// File: rtl/pde_datapath.sv
// ----------------------------------------------------------------------------
// pde_datapath
// History memories, term selection, shared multiply-accumulate and the
// final shift and saturation.
// ----------------------------------------------------------------------------
module pde_datapath #(
    parameter int MAX_TERMS     = pde_pkg::DEF_MAX_TERMS,
    parameter int HISTORY_DEPTH = pde_pkg::DEF_HISTORY_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pde_pkg::pde_op_t              op,
    input  logic [pde_pkg::SAMPLE_W-1:0]  sample,
    input  logic [pde_pkg::COUNT_W-1:0]   term_count,
    input  pde_pkg::term_array_t          terms,
    output logic                          more_terms,
    output logic [pde_pkg::SAMPLE_W-1:0]  filtered,
    output logic                          clipped
);

    localparam int AW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FW     = $clog2(HISTORY_DEPTH + 1);
    localparam int SW     = $clog2(2 * HISTORY_DEPTH + 16);
    localparam int ACC_W  = pde_pkg::PROD_W + $clog2(MAX_TERMS + 1);
    localparam int QW     = ACC_W - pde_pkg::FRAC_W;
    localparam int LIMIT  = (MAX_TERMS < pde_pkg::TERM_REGS) ? MAX_TERMS : pde_pkg::TERM_REGS;
    localparam int CW     = pde_pkg::COUNT_W;

    // Number of terms actually summed.
    logic [CW-1:0] n_eff;
    assign n_eff = (term_count > CW'(LIMIT)) ? CW'(LIMIT) : term_count;

    // History pointers (newest entry) and fill counts.
    logic [AW-1:0] in_ptr_reg,  in_ptr_next;
    logic [AW-1:0] out_ptr_reg, out_ptr_next;
    logic [FW-1:0] in_fill_reg, out_fill_reg;
    logic [CW-1:0] idx_reg;

    assign in_ptr_next  = (in_ptr_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : in_ptr_reg + 1'b1;
    assign out_ptr_next = (out_ptr_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : out_ptr_reg + 1'b1;

    // Term selection and history address.
    logic [pde_pkg::TERM_W-1:0]  term_sel;
    logic                        osel;
    logic [pde_pkg::DELAY_W-1:0] delay;
    logic [pde_pkg::DELAY_W-1:0] tap_dist;
    logic [AW-1:0]               ptr_sel;
    logic [FW-1:0]               fill_sel;
    logic                        hit;
    logic [SW-1:0]               raw_addr;
    logic [SW-1:0]               wrap_addr;
    logic [AW-1:0]               rd_addr;
    logic                        issue_fire;

    assign issue_fire = op.issue && (idx_reg < n_eff);
    assign more_terms = ({1'b0, idx_reg} + 1'b1) < {1'b0, n_eff};

    always_comb begin
        term_sel = (idx_reg < CW'(pde_pkg::TERM_REGS)) ? terms[idx_reg] : '0;
        osel     = term_sel[pde_pkg::OUTSEL_BIT];
        delay    = term_sel[pde_pkg::DELAY_LSB +: pde_pkg::DELAY_W];
        // An output term with no delay falls back to the previous output.
        if (osel && delay != '0) begin
            tap_dist = delay - 1'b1;
        end else begin
            tap_dist = delay;
        end
        ptr_sel   = osel ? out_ptr_reg : in_ptr_reg;
        fill_sel  = osel ? out_fill_reg : in_fill_reg;
        hit       = SW'(tap_dist) < SW'(fill_sel);
        raw_addr  = SW'(ptr_sel) + SW'(HISTORY_DEPTH) - SW'(tap_dist);
        wrap_addr = (raw_addr >= SW'(HISTORY_DEPTH)) ? raw_addr - SW'(HISTORY_DEPTH) : raw_addr;
        rd_addr   = hit ? wrap_addr[AW-1:0] : '0;
    end

    logic [pde_pkg::SAMPLE_W-1:0] in_dout, out_dout;

    pde_ram #(
        .WIDTH (pde_pkg::SAMPLE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_in_ram (
        .aclk    (aclk),
        .wr_en   (op.accept),
        .wr_addr (in_ptr_next),
        .wr_data (sample),
        .rd_en   (issue_fire && !osel),
        .rd_addr (rd_addr),
        .rd_data (in_dout)
    );

    pde_ram #(
        .WIDTH (pde_pkg::SAMPLE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_out_ram (
        .aclk    (aclk),
        .wr_en   (op.finish),
        .wr_addr (out_ptr_next),
        .wr_data (filtered),
        .rd_en   (issue_fire && osel),
        .rd_addr (rd_addr),
        .rd_data (out_dout)
    );

    // Pipeline: read, multiply, accumulate.
    logic                             s1_v_reg, s2_v_reg;
    logic                             s1_hit_reg, s1_osel_reg;
    logic signed [pde_pkg::COEF_W-1:0] s1_coef_reg;
    logic [pde_pkg::SAMPLE_W-1:0]     operand;
    logic signed [pde_pkg::PROD_W-1:0] prod_next, prod_reg;
    logic signed [ACC_W-1:0]          acc_reg;

    assign operand   = s1_hit_reg ? (s1_osel_reg ? out_dout : in_dout) : '0;
    assign prod_next = s1_coef_reg * $signed({1'b0, operand});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_ptr_reg   <= '0;
            out_ptr_reg  <= '0;
            in_fill_reg  <= '0;
            out_fill_reg <= '0;
            idx_reg      <= '0;
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
        end else begin
            if (op.accept) begin
                in_ptr_reg <= in_ptr_next;
                if (in_fill_reg != FW'(HISTORY_DEPTH)) begin
                    in_fill_reg <= in_fill_reg + 1'b1;
                end
                idx_reg <= '0;
            end else if (issue_fire) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (op.finish) begin
                out_ptr_reg <= out_ptr_next;
                if (out_fill_reg != FW'(HISTORY_DEPTH)) begin
                    out_fill_reg <= out_fill_reg + 1'b1;
                end
            end
            s1_v_reg <= issue_fire;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue_fire) begin
            s1_coef_reg <= $signed(term_sel[pde_pkg::COEF_W-1:0]);
            s1_hit_reg  <= hit;
            s1_osel_reg <= osel;
        end
        if (s1_v_reg) begin
            prod_reg <= prod_next;
        end
        if (op.accept) begin
            acc_reg <= '0;
        end else if (s2_v_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // Floor shift, then clamp to the unsigned sample range.
    logic signed [QW-1:0] q;
    assign q = QW'(acc_reg >>> pde_pkg::FRAC_W);

    always_comb begin
        if (q[QW-1]) begin
            filtered = '0;
            clipped  = 1'b1;
        end else if (q[QW-1:pde_pkg::SAMPLE_W] != '0) begin
            filtered = '1;
            clipped  = 1'b1;
        end else begin
            filtered = q[pde_pkg::SAMPLE_W-1:0];
            clipped  = 1'b0;
        end
    end

endmodule

// File: rtl/programmable_difference_equation.sv
// ----------------------------------------------------------------------------
// programmable_difference_equation
// Direct-form-1 IIR filter whose terms are set by registers and walked by a
// small microprogram over one shared multiply-accumulate.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  s_axis    in         tdata: sample x(k)
//  m_axis    out        tdata: filtered y(k); tuser: clipped flag
//  cfg       in         term_count (index 0), term_0..term_6 (index 1..7)
//
// From acceptance to its result, an item passes through these steps: take
// the sample, pass the active terms one per cycle through the shared
// multiply-accumulate, drain its read, multiply and add stages, and load
// the result.
// The result sits in an output register, so the next item is taken while the
// previous result waits; only the final step waits for that register to free.
// Reset idles the sequencer, clears the output valid flag, loads the reset
// configuration and clears the fill counts of both history memories, so
// unwritten history reads as zero and no clearing pass is needed.
// ----------------------------------------------------------------------------
module programmable_difference_equation #(
    parameter int MAX_TERMS     = pde_pkg::DEF_MAX_TERMS,
    parameter int HISTORY_DEPTH = pde_pkg::DEF_HISTORY_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input channel.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,    // [15:0] sample
    // Result channel.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,    // [15:0] filtered
    output logic                          m_tuser,    // [0] clipped
    // Configuration write port.
    input  logic                          cfg_wr_en,
    input  logic [pde_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pde_pkg::TERM_W-1:0]    cfg_wdata
);

    // Configuration registers; the user writes them only while the block is idle (not enforced).
    logic [pde_pkg::COUNT_W-1:0] term_count_reg;
    pde_pkg::term_array_t        term_regs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_count_reg <= pde_pkg::TERM_COUNT_RST;
            term_regs_reg  <= pde_pkg::TERM_REGS_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == pde_pkg::CFG_TERM_COUNT) begin
                term_count_reg <= cfg_wdata[pde_pkg::COUNT_W-1:0];
            end
            for (int i = 0; i < pde_pkg::TERM_REGS; i++) begin
                if (cfg_index == pde_pkg::CFG_IDX_W'(pde_pkg::CFG_TERM_BASE + i)) begin
                    term_regs_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    // Sequencer and the actions it qualifies.
    pde_pkg::ctrl_word_t  ctrl;
    pde_pkg::pde_status_t status;
    pde_pkg::pde_op_t     op;
    logic                 more_terms;
    logic                 out_busy;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [15:0]          filtered_reg;
    logic                 clipped_reg;
    logic [15:0]          filtered;
    logic                 clipped;

    // The output register is free unless it holds an item that is not taken now.
    assign out_busy = m_tvalid_reg && !m_tready;

    assign status.no_input   = !s_tvalid;
    assign status.out_busy   = out_busy;
    assign status.more_terms = more_terms;

    assign s_tready  = ctrl.take_in;
    assign op.accept = s_tvalid && ctrl.take_in;
    assign op.issue  = ctrl.issue;
    assign op.finish = ctrl.finish && !out_busy;

    pde_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    pde_datapath #(
        .MAX_TERMS     (MAX_TERMS),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op         (op),
        .sample     (s_tdata),
        .term_count (term_count_reg),
        .terms      (term_regs_reg),
        .more_terms (more_terms),
        .filtered   (filtered),
        .clipped    (clipped)
    );

    // Output register.
    always_comb begin
        if (op.finish) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (op.finish) begin
            filtered_reg <= filtered;
            clipped_reg  <= clipped;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = filtered_reg;
    assign m_tuser  = clipped_reg;

endmodule
